// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the window fill byte sequencer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in every cycle in which ante holds
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequencer implication check failed");

// Check that cond holds in every cycle out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    `ASSERT_IMPLIES(label, clk, rst_n, 1'b1, cond)

`endif

// ===== src/lwfs_pkg.sv =====
// ----------------------------------------------------------------------------
// lwfs_pkg
// Types, codes and constants of the LCD window fill byte sequencer.
// ----------------------------------------------------------------------------
package lwfs_pkg;

    localparam int MAX_DIM_DEF      = 512;
    localparam int FILL_BURST_DEF   = 16;
    localparam int MAX_RESULTS      = 32;
    localparam int CHUNK_CAP_MAX    = MAX_RESULTS / 2;
    localparam int COUNT_W          = $clog2(CHUNK_CAP_MAX + 1);
    localparam int STEP_W           = $clog2(MAX_RESULTS);
    localparam int ADDR_W           = 11;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 10;

    localparam logic [1:0] FUNC_WINDOW = 2'd0;
    localparam logic [1:0] FUNC_PIXEL  = 2'd1;
    localparam logic [1:0] FUNC_FILL   = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_ARG   = 2'd1;
    localparam logic [1:0] ST_NOT_READY = 2'd2;
    localparam logic [1:0] ST_NO_WINDOW = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_PANEL_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PANEL_HEIGHT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COL_SHIFT     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_SHIFT     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PANEL_READY   = 3'd4;

    localparam logic [9:0] PANEL_WIDTH_RST  = 10'd240;
    localparam logic [9:0] PANEL_HEIGHT_RST = 10'd320;

    localparam logic [7:0] CMD_COLUMN   = 8'h2a;
    localparam logic [7:0] CMD_ROW      = 8'h2b;
    localparam logic [7:0] CMD_MEMWRITE = 8'h2c;

    localparam logic [STEP_W-1:0] WIN_STEP_COL_CMD = STEP_W'(0);
    localparam logic [STEP_W-1:0] WIN_STEP_COL_FH  = STEP_W'(1);
    localparam logic [STEP_W-1:0] WIN_STEP_COL_FL  = STEP_W'(2);
    localparam logic [STEP_W-1:0] WIN_STEP_COL_LH  = STEP_W'(3);
    localparam logic [STEP_W-1:0] WIN_STEP_COL_LL  = STEP_W'(4);
    localparam logic [STEP_W-1:0] WIN_STEP_ROW_CMD = STEP_W'(5);
    localparam logic [STEP_W-1:0] WIN_STEP_ROW_FH  = STEP_W'(6);
    localparam logic [STEP_W-1:0] WIN_STEP_ROW_FL  = STEP_W'(7);
    localparam logic [STEP_W-1:0] WIN_STEP_ROW_LH  = STEP_W'(8);
    localparam logic [STEP_W-1:0] WIN_STEP_ROW_LL  = STEP_W'(9);
    localparam logic [STEP_W-1:0] WIN_STEP_MEMWR   = STEP_W'(10);

    typedef struct packed {
        logic [1:0]  func;
        logic [8:0]  win_x;
        logic [8:0]  win_y;
        logic [9:0]  win_width;
        logic [9:0]  win_height;
        logic [15:0] pixel_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       end_of_transaction;
        logic [1:0] status;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [9:0] panel_width;
        logic [9:0] panel_height;
        logic [8:0] col_shift;
        logic [8:0] row_shift;
        logic       panel_ready;
    } cfg_t;

    typedef enum logic [1:0] {
        JOB_ERROR,
        JOB_WINDOW,
        JOB_PIXELS
    } job_kind_t;

    typedef struct packed {
        job_kind_t           kind;
        logic [1:0]          status;
        logic [ADDR_W-1:0]   col_first;
        logic [ADDR_W-1:0]   col_last;
        logic [ADDR_W-1:0]   row_first;
        logic [ADDR_W-1:0]   row_last;
        logic [15:0]         pixel_value;
        logic [COUNT_W-1:0]  count;
        logic                stream_end;
    } job_t;

endpackage

// ===== src/lwfs_front.sv =====
// ----------------------------------------------------------------------------
// lwfs_front
// Accepts items, checks them against the panel and the pixel counter, and
// turns each into one job for the byte sequencer.
// ----------------------------------------------------------------------------
module lwfs_front #(
    parameter int MAX_DIM    = lwfs_pkg::MAX_DIM_DEF,
    parameter int FILL_BURST = lwfs_pkg::FILL_BURST_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  lwfs_pkg::in_item_t item,
    input  lwfs_pkg::cfg_t     cfg,
    input  logic               queue_full,
    output logic               push,
    output lwfs_pkg::job_t     push_job
);
    import lwfs_pkg::*;

    localparam int DIM_LIM = (MAX_DIM < 1023) ? MAX_DIM : 1023;
    localparam int CNT_W   = $clog2(DIM_LIM * DIM_LIM + 1);
    localparam int CAP     = (FILL_BURST < CHUNK_CAP_MAX) ? FILL_BURST : CHUNK_CAP_MAX;
    localparam int CMP_W   = ($clog2(MAX_DIM + 1) > 11) ? $clog2(MAX_DIM + 1) : 11;

    logic [CNT_W-1:0] remaining_reg;
    logic [CNT_W-1:0] remaining_next;
    logic [CNT_W-1:0] take;
    logic [CNT_W-1:0] left;
    logic [19:0]      area;
    logic [10:0]      col_end;
    logic [10:0]      row_end;
    logic [CMP_W-1:0] col_end_ext;
    logic [CMP_W-1:0] row_end_ext;
    logic             window_bad;
    job_t             job;

    assign item_ready = !queue_full;
    assign push       = item_valid && item_ready;
    assign push_job   = job;

    always_comb
    begin
        col_end     = 11'(item.win_x) + 11'(item.win_width);
        row_end     = 11'(item.win_y) + 11'(item.win_height);
        col_end_ext = CMP_W'(col_end);
        row_end_ext = CMP_W'(row_end);
        window_bad  = (item.win_width == 10'd0) || (item.win_height == 10'd0)
                   || (col_end > 11'(cfg.panel_width))
                   || (row_end > 11'(cfg.panel_height))
                   || (col_end_ext > CMP_W'(MAX_DIM))
                   || (row_end_ext > CMP_W'(MAX_DIM));
        area        = 20'(item.win_width) * 20'(item.win_height);

        if (item.func == FUNC_PIXEL)
        begin
            take = CNT_W'(1);
        end
        else if (remaining_reg < CNT_W'(CAP))
        begin
            take = remaining_reg;
        end
        else
        begin
            take = CNT_W'(CAP);
        end
        left = remaining_reg - take;

        job             = '0;
        job.kind        = JOB_ERROR;
        job.status      = ST_OK;
        job.pixel_value = item.pixel_value;
        remaining_next  = remaining_reg;

        priority if (!cfg.panel_ready)
        begin
            job.status = ST_NOT_READY;
        end
        else if (item.func == FUNC_UNUSED)
        begin
            job.status = ST_BAD_ARG;
        end
        else if (item.func == FUNC_WINDOW)
        begin
            if (window_bad)
            begin
                job.status = ST_BAD_ARG;
            end
            else
            begin
                job.kind       = JOB_WINDOW;
                job.col_first  = ADDR_W'(item.win_x) + ADDR_W'(cfg.col_shift);
                job.col_last   = job.col_first + ADDR_W'(item.win_width) - ADDR_W'(1);
                job.row_first  = ADDR_W'(item.win_y) + ADDR_W'(cfg.row_shift);
                job.row_last   = job.row_first + ADDR_W'(item.win_height) - ADDR_W'(1);
                remaining_next = CNT_W'(area);
            end
        end
        else if (remaining_reg == '0)
        begin
            job.status = ST_NO_WINDOW;
        end
        else
        begin
            job.kind       = JOB_PIXELS;
            job.count      = COUNT_W'(take);
            job.stream_end = (left == '0);
            remaining_next = left;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
        end
        else if (push)
        begin
            remaining_reg <= remaining_next;
        end
    end

endmodule

// ===== src/lwfs_queue.sv =====
// ----------------------------------------------------------------------------
// lwfs_queue
// Two-entry job queue between the checking front and the byte sequencer.
// ----------------------------------------------------------------------------
module lwfs_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lwfs_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output lwfs_pkg::job_t head
);
    import lwfs_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== src/lwfs_back.sv =====
// ----------------------------------------------------------------------------
// lwfs_back
// Walks the head job one byte per unstalled cycle into the registered result stage.
// ----------------------------------------------------------------------------
module lwfs_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  lwfs_pkg::job_t      head,
    output logic                pop,
    output logic                result_valid,
    input  logic                result_ready,
    output lwfs_pkg::out_item_t result
);
    import lwfs_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic              out_valid_reg;
    out_item_t         out_data_reg;
    out_item_t         gen;
    logic [STEP_W:0]   pix_last_wide;
    logic [STEP_W-1:0] pix_last;
    logic              advance;

    assign advance      = head_valid && (!out_valid_reg || result_ready);
    assign pop          = advance && gen.last;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    always_comb
    begin
        pix_last_wide = {(STEP_W + 1 - COUNT_W)'(0), head.count} * (STEP_W + 1)'(2)
                      - (STEP_W + 1)'(1);
        pix_last      = pix_last_wide[STEP_W-1:0];

        gen        = '0;
        gen.status = ST_OK;
        unique case (head.kind)
            JOB_WINDOW:
            begin
                gen.is_data = 1'b1;
                unique case (step_reg)
                    WIN_STEP_COL_CMD:
                    begin
                        gen.out_byte = CMD_COLUMN;
                        gen.is_data  = 1'b0;
                    end
                    WIN_STEP_COL_FH: gen.out_byte = 8'(head.col_first >> 8);
                    WIN_STEP_COL_FL: gen.out_byte = head.col_first[7:0];
                    WIN_STEP_COL_LH: gen.out_byte = 8'(head.col_last >> 8);
                    WIN_STEP_COL_LL:
                    begin
                        gen.out_byte           = head.col_last[7:0];
                        gen.end_of_transaction = 1'b1;
                    end
                    WIN_STEP_ROW_CMD:
                    begin
                        gen.out_byte = CMD_ROW;
                        gen.is_data  = 1'b0;
                    end
                    WIN_STEP_ROW_FH: gen.out_byte = 8'(head.row_first >> 8);
                    WIN_STEP_ROW_FL: gen.out_byte = head.row_first[7:0];
                    WIN_STEP_ROW_LH: gen.out_byte = 8'(head.row_last >> 8);
                    WIN_STEP_ROW_LL:
                    begin
                        gen.out_byte           = head.row_last[7:0];
                        gen.end_of_transaction = 1'b1;
                    end
                    WIN_STEP_MEMWR:
                    begin
                        gen.out_byte           = CMD_MEMWRITE;
                        gen.is_data            = 1'b0;
                        gen.end_of_transaction = 1'b1;
                        gen.last               = 1'b1;
                    end
                    default:
                    begin
                        gen.out_byte = 8'd0;
                        gen.last     = 1'b1;
                    end
                endcase
            end
            JOB_PIXELS:
            begin
                gen.is_data            = 1'b1;
                gen.out_byte           = step_reg[0] ? head.pixel_value[7:0]
                                                     : head.pixel_value[15:8];
                gen.last               = (step_reg == pix_last);
                gen.end_of_transaction = gen.last && head.stream_end;
            end
            default:
            begin
                gen.status = head.status;
                gen.last   = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
            step_reg      <= gen.last ? '0 : step_reg + STEP_W'(1);
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= gen;
        end
    end

endmodule

// ===== src/lcd_window_fill_byte_sequencer.sv =====
// ----------------------------------------------------------------------------
// lcd_window_fill_byte_sequencer
// Command and data byte stream for an SPI RGB565 panel window write.
// ----------------------------------------------------------------------------
// The result port delivers one byte per clock while it is not stalled. An item
// yields eleven bytes for an open window, two for a pixel, twice the pixel
// count (at most 2 * min(FILL_BURST, 16), so 32 at the defaults) for a fill
// and one for any error. The byte sequencer walks the head job of a two-entry
// queue one byte per unstalled cycle into the output register; the checking
// front takes a new item every cycle while the queue has room. Configuration
// writes are taken at once and are meant for idle periods only.
`include "assert_macros.svh"

module lcd_window_fill_byte_sequencer #(
    parameter int MAX_DIM    = lwfs_pkg::MAX_DIM_DEF,
    parameter int FILL_BURST = lwfs_pkg::FILL_BURST_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  lwfs_pkg::in_item_t                   item,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output lwfs_pkg::out_item_t                  result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lwfs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [lwfs_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import lwfs_pkg::*;

    cfg_t cfg_reg;
    logic push;
    job_t push_job;
    logic queue_full;
    logic pop;
    logic head_valid;
    job_t head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.panel_width  <= PANEL_WIDTH_RST;
            cfg_reg.panel_height <= PANEL_HEIGHT_RST;
            cfg_reg.col_shift    <= 9'd0;
            cfg_reg.row_shift    <= 9'd0;
            cfg_reg.panel_ready  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PANEL_WIDTH:  cfg_reg.panel_width  <= cfg_data;
                CFG_PANEL_HEIGHT: cfg_reg.panel_height <= cfg_data;
                CFG_COL_SHIFT:    cfg_reg.col_shift    <= cfg_data[8:0];
                CFG_ROW_SHIFT:    cfg_reg.row_shift    <= cfg_data[8:0];
                CFG_PANEL_READY:  cfg_reg.panel_ready  <= cfg_data[0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    lwfs_front #(
        .MAX_DIM    (MAX_DIM),
        .FILL_BURST (FILL_BURST)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cfg        (cfg_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    lwfs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    lwfs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    `ASSERT_IMPLIES(a_error_single, clk, rst_n, result_valid && (result.status != ST_OK), result.last && !result.is_data && (result.out_byte == 8'd0))
    `ASSERT_IMPLIES(a_cmd_end_memwr, clk, rst_n, result_valid && result.end_of_transaction && !result.is_data, (result.out_byte == CMD_MEMWRITE) && result.last)
    `ASSERT_IMPLIES(a_empty_accepts, clk, rst_n, !head_valid, item_ready)

endmodule
